[src/normal_lighting_color_transform_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the normal lighting color transform core
// Shared property wrappers, clocked on clk and disabled during arst_n reset.
// ----------------------------------------------------------------------------
`ifndef NORMAL_LIGHTING_COLOR_TRANSFORM_CORE_MACROS_SVH
`define NORMAL_LIGHTING_COLOR_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication
`define NLCT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nlct assertion failed");

// Next-cycle implication
`define NLCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nlct assertion failed");

`endif

[src/nlct_pkg.sv]
// ----------------------------------------------------------------------------
// nlct_pkg
// Types, register indexes and constants of the lighting color transform.
// ----------------------------------------------------------------------------
package nlct_pkg;

	localparam int unsigned FRAC_BITS = 12;

	typedef logic signed [15:0] lane_t;
	typedef logic signed [31:0] prod_t;
	typedef logic [2:0][15:0]   row_t;

	typedef enum logic [2:0] {
		REG_LIGHT_ROW1  = 3'd0,
		REG_LIGHT_ROW2  = 3'd1,
		REG_LIGHT_ROW3  = 3'd2,
		REG_COLOR_RED   = 3'd3,
		REG_COLOR_GREEN = 3'd4,
		REG_COLOR_BLUE  = 3'd5,
		REG_BACKGROUND  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		row_t [2:0] light;
		row_t [2:0] color;
		row_t       bg;
	} cfg_t;

	localparam lane_t IR_MAX    = 16'sh7FFF;
	localparam lane_t IR_MIN    = -16'sh8000;
	localparam logic [7:0] COLOR_MAX = 8'hFF;

endpackage

[src/nlct_cfg_regs.sv]
// ----------------------------------------------------------------------------
// nlct_cfg_regs
// Light, color and background register file with a single write port.
// ----------------------------------------------------------------------------
module nlct_cfg_regs
	import nlct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [47:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_LIGHT_ROW1:  cfg_q.light[0] <= wr_data;
				REG_LIGHT_ROW2:  cfg_q.light[1] <= wr_data;
				REG_LIGHT_ROW3:  cfg_q.light[2] <= wr_data;
				REG_COLOR_RED:   cfg_q.color[0] <= wr_data;
				REG_COLOR_GREEN: cfg_q.color[1] <= wr_data;
				REG_COLOR_BLUE:  cfg_q.color[2] <= wr_data;
				REG_BACKGROUND:  cfg_q.bg       <= wr_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/nlct_mat_mul.sv]
// ----------------------------------------------------------------------------
// nlct_mat_mul
// Nine signed 16x16 products of a 3x3 matrix and a vector, registered.
// ----------------------------------------------------------------------------
module nlct_mat_mul
	import nlct_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  lane_t vec [3],
	input  row_t  mat [3],
	output prod_t prod [3][3]
);

	prod_t prod_q [3][3];

	// Hold the products while the stage is stalled
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_q[r][c] <= $signed(mat[r][c]) * vec[c];
				end
			end
		end
	end

	assign prod = prod_q;

endmodule

[src/normal_lighting_color_transform_core.sv]
// ----------------------------------------------------------------------------
// normal_lighting_color_transform_core
// Per-vertex normal lighting: light matrix, IR saturation, color matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one surface normal per
//   transaction: normal_x, normal_y, normal_z, signed 4.12.
//   Output channel (out_valid / out_stall) returns one result per normal:
//   the three raw light sums (low 32 bits), the saturated IR vector and the
//   clamped 8-bit red, green and blue.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
//   writes the seven 48-bit registers; cfg_ready is always high. Write only
//   while no transaction is in flight.
//   An accepted input passes the stage 1 to 4 registers before out_valid;
//   throughput is one vertex per cycle while unstalled, set by the four-stage
//   pipeline (light products, light sums, color products, color sums).
//   Reset clears all configuration registers and every stage valid bit.
//   While the receiver stalls, the output stage holds its result; earlier
//   stages keep advancing into empty slots, and in_stall rises only once
//   every stage is full.
// ----------------------------------------------------------------------------
`include "normal_lighting_color_transform_core_macros.svh"

module normal_lighting_color_transform_core
	import nlct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] light_acc_1,
	output logic signed [31:0] light_acc_2,
	output logic signed [31:0] light_acc_3,
	output logic signed [15:0] light_ir_1,
	output logic signed [15:0] light_ir_2,
	output logic signed [15:0] light_ir_3,
	output logic [7:0]         color_red,
	output logic [7:0]         color_green,
	output logic [7:0]         color_blue
);

	cfg_t cfg;

	// Stage valid bits and per-stage advance enables
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	lane_t nrm [3];
	row_t  light_mat [3];
	row_t  color_mat [3];
	prod_t light_prod_s1 [3][3];
	prod_t color_prod_s3 [3][3];

	logic signed [31:0] acc_s2 [3];
	lane_t              ir_s2  [3];
	logic signed [31:0] acc_s3 [3];
	lane_t              ir_s3  [3];
	logic signed [31:0] acc_s4 [3];
	lane_t              ir_s4  [3];
	logic [7:0]         rgb_s4 [3];

	logic signed [33:0] lsum   [3];
	logic signed [33:0] lshift [3];
	lane_t              lsat   [3];
	logic signed [34:0] csum   [3];
	logic signed [34:0] cshift [3];
	logic [7:0]         cclamp [3];

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	nlct_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// ------------------------------------------------------------ flow control
	// A stage advances when it is empty or the stage behind it advances,
	// so bubbles collapse while the output is stalled.
	assign en4      = !valid_s4 || !out_stall;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// --------------------------------------------- stage 1: light products
	assign nrm[0] = normal_x;
	assign nrm[1] = normal_y;
	assign nrm[2] = normal_z;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			light_mat[r] = cfg.light[r];
			color_mat[r] = cfg.color[r];
		end
	end

	nlct_mat_mul u_light_mul (
		.clk  (clk),
		.en   (en1),
		.vec  (nrm),
		.mat  (light_mat),
		.prod (light_prod_s1)
	);

	// ------------------------------------ stage 2: light sums and IR saturate
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			lsum[r]   = 34'(light_prod_s1[r][0]) + 34'(light_prod_s1[r][1])
				+ 34'(light_prod_s1[r][2]);
			lshift[r] = lsum[r] >>> FRAC_BITS;
			// fits in 16 bits when bits 33..15 all match the sign
			if ((&lshift[r][33:15]) || !(|lshift[r][33:15])) begin
				lsat[r] = lshift[r][15:0];
			end else begin
				lsat[r] = lshift[r][33] ? IR_MIN : IR_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int r = 0; r < 3; r++) begin
				acc_s2[r] <= lsum[r][31:0];
				ir_s2[r]  <= lsat[r];
			end
		end
	end

	// --------------------------------------------- stage 3: color products
	nlct_mat_mul u_color_mul (
		.clk  (clk),
		.en   (en3),
		.vec  (ir_s2),
		.mat  (color_mat),
		.prod (color_prod_s3)
	);

	always_ff @(posedge clk) begin
		if (en3) begin
			acc_s3 <= acc_s2;
			ir_s3  <= ir_s2;
		end
	end

	// ------------------------------ stage 4: background add, shift and clamp
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			csum[c]   = 35'(color_prod_s3[c][0]) + 35'(color_prod_s3[c][1])
				+ 35'(color_prod_s3[c][2])
				+ $signed({7'd0, cfg.bg[c], {FRAC_BITS{1'b0}}});
			cshift[c] = csum[c] >>> FRAC_BITS;
			if (cshift[c][34]) begin
				cclamp[c] = 8'd0;
			end else if (|cshift[c][33:8]) begin
				cclamp[c] = COLOR_MAX;
			end else begin
				cclamp[c] = cshift[c][7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			acc_s4 <= acc_s3;
			ir_s4  <= ir_s3;
			rgb_s4 <= cclamp;
		end
	end

	// ---------------------------------------------------------------- output
	assign out_valid   = valid_s4;
	assign light_acc_1 = acc_s4[0];
	assign light_acc_2 = acc_s4[1];
	assign light_acc_3 = acc_s4[2];
	assign light_ir_1  = ir_s4[0];
	assign light_ir_2  = ir_s4[1];
	assign light_ir_3  = ir_s4[2];
	assign color_red   = rgb_s4[0];
	assign color_green = rgb_s4[1];
	assign color_blue  = rgb_s4[2];

	// ------------------------------------------------------------ assertions
	// Input stalls only when every stage is full and the output is stalled
	`NLCT_ASSERT_NOW(a_stall_only_full, in_stall,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && out_stall)
	// A full stage 1 that advances lands in stage 2
	`NLCT_ASSERT_NEXT(a_s1_to_s2, valid_s1 && en2, valid_s2)
	// A full stage 3 that advances becomes a visible result
	`NLCT_ASSERT_NEXT(a_s3_to_out, valid_s3 && en4, out_valid)

endmodule

[tb/tb_normal_lighting_color_transform_core.sv]
// ----------------------------------------------------------------------------
// tb_normal_lighting_color_transform_core
// Self-checking bench: streams surface normals through the lighting core
// under several light/color/background settings and compares every result
// transaction field by field against a cycle-free model of the arithmetic.
// ----------------------------------------------------------------------------
module tb_normal_lighting_color_transform_core
	import nlct_pkg::*;
();

	// Four pipeline stages from input transaction to out_valid.
	localparam int PIPE_DEPTH     = 4;
	localparam int CLK_PERIOD     = 10;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 50;
	localparam int N_DIRECTED     = 22;

	// Index beyond the register file: the core must drop such writes.
	localparam logic [2:0] REG_UNUSED = 3'd7;

	// One result transaction, lane 0 holds channel 1 / red.
	typedef struct packed {
		logic [2:0][31:0] acc;
		logic [2:0][15:0] ir;
		logic [2:0][7:0]  rgb;
	} lit_result_t;

	localparam lit_result_t ZERO_RESULT = '0;

	// Fixed register settings used by the directed rows.
	typedef enum logic [2:0] {
		SET_RESET,
		SET_UNIT,
		SET_FINE,
		SET_MAX_POS,
		SET_MAX_NEG
	} cfg_setting_e;

	typedef struct packed {
		cfg_setting_e setting;
		logic [15:0]  nx;
		logic [15:0]  ny;
		logic [15:0]  nz;
		bit           typed;
		lit_result_t  want;
	} directed_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [47:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] light_acc_1;
	logic signed [31:0] light_acc_2;
	logic signed [31:0] light_acc_3;
	logic signed [15:0] light_ir_1;
	logic signed [15:0] light_ir_2;
	logic signed [15:0] light_ir_3;
	logic [7:0]         color_red;
	logic [7:0]         color_green;
	logic [7:0]         color_blue;

	// Shadow copy of the register file, updated on every accepted write.
	row_t light_m [3] = '{default: '0};
	row_t color_m [3] = '{default: '0};
	row_t bg_m        = '0;

	lit_result_t pending_results [$];
	int          error_count = 0;
	int          stall_left  = 0;
	bit          no_idle     = 1'b0;
	string       rgb_names [3] = '{"red", "green", "blue"};

	// Directed rows. Typed rows run on the reset register values, where every
	// product is zero; the rest go through the predictor.
	directed_row_t stim_table [N_DIRECTED] = '{
		'{SET_RESET,   16'h0000, 16'h0000, 16'h0000, 1'b1, ZERO_RESULT},
		'{SET_RESET,   16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, ZERO_RESULT},
		'{SET_RESET,   16'h8000, 16'h8000, 16'h8000, 1'b1, ZERO_RESULT},
		'{SET_UNIT,    16'h1000, 16'h0000, 16'h0000, 1'b0, ZERO_RESULT},
		'{SET_UNIT,    16'h0000, 16'h1000, 16'h0000, 1'b0, ZERO_RESULT},
		'{SET_UNIT,    16'h0000, 16'h0000, 16'h1000, 1'b0, ZERO_RESULT},
		'{SET_UNIT,    16'hF000, 16'h0000, 16'h0000, 1'b0, ZERO_RESULT},
		'{SET_UNIT,    16'h0800, 16'h0800, 16'h0800, 1'b0, ZERO_RESULT},
		'{SET_UNIT,    16'h0010, 16'h0020, 16'h0040, 1'b0, ZERO_RESULT},
		'{SET_UNIT,    16'h7FFF, 16'h8000, 16'h0000, 1'b0, ZERO_RESULT},
		'{SET_FINE,    16'hFFFF, 16'h0000, 16'h0000, 1'b0, ZERO_RESULT},
		'{SET_FINE,    16'h0001, 16'h0000, 16'h0000, 1'b0, ZERO_RESULT},
		'{SET_FINE,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, ZERO_RESULT},
		'{SET_FINE,    16'h0FFF, 16'h0000, 16'h0000, 1'b0, ZERO_RESULT},
		'{SET_FINE,    16'h1000, 16'h0000, 16'h0000, 1'b0, ZERO_RESULT},
		'{SET_MAX_POS, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, ZERO_RESULT},
		'{SET_MAX_POS, 16'h8000, 16'h8000, 16'h8000, 1'b0, ZERO_RESULT},
		'{SET_MAX_POS, 16'h0000, 16'h0000, 16'h0000, 1'b0, ZERO_RESULT},
		'{SET_MAX_POS, 16'h0001, 16'h0000, 16'h0000, 1'b0, ZERO_RESULT},
		'{SET_MAX_NEG, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, ZERO_RESULT},
		'{SET_MAX_NEG, 16'h8000, 16'h8000, 16'h8000, 1'b0, ZERO_RESULT},
		'{SET_MAX_NEG, 16'h0000, 16'h0000, 16'h0000, 1'b0, ZERO_RESULT}
	};

	normal_lighting_color_transform_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.light_acc_1 (light_acc_1),
		.light_acc_2 (light_acc_2),
		.light_acc_3 (light_acc_3),
		.light_ir_1  (light_ir_1),
		.light_ir_2  (light_ir_2),
		.light_ir_3  (light_ir_3),
		.color_red   (color_red),
		.color_green (color_green),
		.color_blue  (color_blue)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Sign-extend one 16-bit coefficient lane.
	function automatic longint lane_value(row_t row, int k);
		return longint'($signed(row[k]));
	endfunction

	// Light matrix, IR saturation, then color matrix plus background. All
	// sums are kept at 64 bits so nothing wraps before the final truncation.
	function automatic lit_result_t predict_lighting(lane_t nx, lane_t ny, lane_t nz);
		longint      nrm [3];
		longint      ir [3];
		longint      sum;
		lit_result_t res;
		nrm[0] = nx;
		nrm[1] = ny;
		nrm[2] = nz;
		for (int i = 0; i < 3; i++) begin
			sum = 0;
			for (int k = 0; k < 3; k++)
				sum += lane_value(light_m[i], k) * nrm[k];
			res.acc[i] = sum[31:0];
			// Arithmetic shift: negative sums round toward minus infinity.
			sum = sum >>> FRAC_BITS;
			if (sum > IR_MAX)
				sum = IR_MAX;
			else if (sum < IR_MIN)
				sum = IR_MIN;
			ir[i]     = sum;
			res.ir[i] = sum[15:0];
		end
		for (int i = 0; i < 3; i++) begin
			// Background lanes are unsigned: zero-extend before scaling.
			sum = longint'(bg_m[i]) << FRAC_BITS;
			for (int k = 0; k < 3; k++)
				sum += lane_value(color_m[i], k) * ir[k];
			sum = sum >>> FRAC_BITS;
			if (sum > longint'(COLOR_MAX))
				sum = longint'(COLOR_MAX);
			else if (sum < 0)
				sum = 0;
			res.rgb[i] = sum[7:0];
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------------

	task automatic flag_error(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Idle cycles before the next transaction on either side.
	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 12);
	endfunction

	// 16-bit value with a bias toward the extremes; bits narrows the random
	// magnitude so that sums stay out of saturation most of the time.
	function automatic logic [15:0] pick_value(int unsigned bits);
		logic [15:0] v;
		case ($urandom_range(0, 11))
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2: v = 16'h0000;
			3: v = 16'hFFFF;
			default: begin
				v = 16'($urandom());
				if (bits < 16)
					v = $signed(v) >>> (16 - bits);
			end
		endcase
		return v;
	endfunction

	// Write one register and mirror it into the shadow copy.
	task automatic write_reg(logic [2:0] idx, row_t data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_LIGHT_ROW1:  light_m[0] = data;
			REG_LIGHT_ROW2:  light_m[1] = data;
			REG_LIGHT_ROW3:  light_m[2] = data;
			REG_COLOR_RED:   color_m[0] = data;
			REG_COLOR_GREEN: color_m[1] = data;
			REG_COLOR_BLUE:  color_m[2] = data;
			REG_BACKGROUND:  bg_m       = data;
			default: ; // out of range: the core drops it, so does the shadow
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_matrices(row_t lt [3], row_t cl [3], row_t bg);
		write_reg(REG_LIGHT_ROW1, lt[0]);
		write_reg(REG_LIGHT_ROW2, lt[1]);
		write_reg(REG_LIGHT_ROW3, lt[2]);
		write_reg(REG_COLOR_RED, cl[0]);
		write_reg(REG_COLOR_GREEN, cl[1]);
		write_reg(REG_COLOR_BLUE, cl[2]);
		write_reg(REG_BACKGROUND, bg);
	endtask

	task automatic apply_setting(cfg_setting_e setting);
		row_t lt [3];
		row_t cl [3];
		row_t bg;
		case (setting)
			SET_UNIT: begin
				lt = '{48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000};
				cl = lt;
				bg = 48'h0000_0040_0080;
			end
			SET_FINE: begin
				lt = '{default: 48'h0001_0001_0001};
				cl = lt;
				bg = '0;
			end
			SET_MAX_POS: begin
				lt = '{default: 48'h7FFF_7FFF_7FFF};
				cl = lt;
				bg = 48'hFFFF_FFFF_FFFF;
			end
			SET_MAX_NEG: begin
				lt = '{default: 48'h8000_8000_8000};
				cl = lt;
				bg = '0;
			end
			default: begin
				lt = '{default: '0};
				cl = lt;
				bg = '0;
			end
		endcase
		load_matrices(lt, cl, bg);
	endtask

	// Random matrices; narrow lanes keep the colors off the clamp rails.
	task automatic apply_random_setting(int unsigned bits, bit poke_unused);
		row_t lt [3];
		row_t cl [3];
		row_t bg;
		for (int i = 0; i < 3; i++) begin
			lt[i] = {pick_value(bits), pick_value(bits), pick_value(bits)};
			cl[i] = {pick_value(bits), pick_value(bits), pick_value(bits)};
		end
		if (bits < 16)
			bg = {16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
				16'($urandom_range(0, 255))};
		else
			bg = {pick_value(16), pick_value(16), pick_value(16)};
		load_matrices(lt, cl, bg);
		if (poke_unused)
			write_reg(REG_UNUSED, 48'({$urandom(), $urandom()}));
	endtask

	// Drop valid and hold until every expected result has come back.
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	// Present one normal after a random gap and hold it until accepted.
	// Valid stays high across back-to-back transactions.
	task automatic send_normal(lane_t nx, lane_t ny, lane_t nz, bit typed,
		lit_result_t want);
		int gap;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		normal_x = nx;
		normal_y = ny;
		normal_z = nz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(typed ? want : predict_lighting(nx, ny, nz));
	endtask

	// ------------------------------------------------------------------------
	// Receiver: stall for a random number of cycles after each result
	// ------------------------------------------------------------------------
	initial begin : drive_out_stall
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker: compare each result transaction with the oldest entry
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		lit_result_t got;
		lit_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			stall_left = draw_wait();
			got.acc = {light_acc_3, light_acc_2, light_acc_1};
			got.ir  = {light_ir_3, light_ir_2, light_ir_1};
			got.rgb = {color_blue, color_green, color_red};
			if (pending_results.size() == 0) begin
				flag_error("result transaction with no expectation pending");
			end else begin
				exp_res = pending_results.pop_front();
				for (int i = 0; i < 3; i++) begin
					if (got.acc[i] !== exp_res.acc[i])
						flag_error($sformatf("light_acc_%0d: got %h, expected %h",
							i + 1, got.acc[i], exp_res.acc[i]));
					if (got.ir[i] !== exp_res.ir[i])
						flag_error($sformatf("light_ir_%0d: got %h, expected %h",
							i + 1, got.ir[i], exp_res.ir[i]));
					if (got.rgb[i] !== exp_res.rgb[i])
						flag_error($sformatf("color_%s: got %h, expected %h",
							rgb_names[i], got.rgb[i], exp_res.rgb[i]));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if the pipeline hangs
	// ------------------------------------------------------------------------
	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("normal_lighting_color_transform_core regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		cfg_setting_e cur_setting;
		int unsigned  phase_bits;
		int unsigned  item_bits;

		// Drive every input to a known value before reset releases.
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		normal_x  = '0;
		normal_y  = '0;
		normal_z  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: drain and reload registers whenever the setting
		// column changes, so writes only land on an idle core.
		cur_setting = SET_RESET;
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (stim_table[i].setting != cur_setting) begin
				drain_pipeline();
				apply_setting(stim_table[i].setting);
				cur_setting = stim_table[i].setting;
			end
			send_normal(stim_table[i].nx, stim_table[i].ny, stim_table[i].nz,
				stim_table[i].typed, stim_table[i].want);
		end

		// Random phases: new matrices per phase, mostly narrow values so the
		// colors land mid-range, with full-scale phases mixed in.
		for (int p = 0; p < PHASES; p++) begin
			drain_pipeline();
			phase_bits = (p % 3 == 1) ? 16 : 13;
			no_idle    = (p == 3);
			apply_random_setting(phase_bits, p == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Hold the sender once until the pipeline is empty.
				if (p == 2 && n == PHASE_ITEMS / 2)
					drain_pipeline();
				item_bits = ($urandom_range(0, 4) == 0) ? 16 : phase_bits;
				send_normal(pick_value(item_bits), pick_value(item_bits),
					pick_value(item_bits), 1'b0, ZERO_RESULT);
			end
		end
		no_idle = 1'b0;

		// Wait out the last results, then watch for strays.
		drain_pipeline();
		repeat (4 * PIPE_DEPTH) @(posedge clk);
		if (error_count == 0)
			$display("normal_lighting_color_transform_core regression: pass");
		else
			$display("normal_lighting_color_transform_core regression: fail");
		$finish;
	end

endmodule

[normal_lighting_color_transform_core.f]
+incdir+src
src/nlct_pkg.sv
src/nlct_cfg_regs.sv
src/nlct_mat_mul.sv
src/normal_lighting_color_transform_core.sv
tb/tb_normal_lighting_color_transform_core.sv
